@@ src/lcg48_pkg.sv @@
// Package for the 48-bit LCG random draw block.
// Holds shared constants, operation codes and controller/datapath command types.
package lcg48_pkg;

  localparam logic [47:0] LcgMult = 48'h0005DEECE66D;
  localparam logic [47:0] LcgInc  = 48'h00000000000B;

  typedef enum logic [2:0] {
    OP_RESEED = 3'd0,
    OP_BITS   = 3'd1,
    OP_BOUNDED = 3'd2,
    OP_LONG   = 3'd3,
    OP_DOUBLE = 3'd4
  } op_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture input transaction
    logic reseed;     // load scrambled seed
    logic step_start; // start one LCG step (multiply)
    logic step_done;  // commit stepped state
    logic div_start;  // start modulo of draw by bound
    logic div_step;   // one restoring-division step
    logic set_hi;     // latch first draw for long/double
    logic set_result; // form final value
    logic set_error;  // nonpositive bound
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       bound_bad;
    logic       bound_pow2;
    logic       div_last;
    logic       reject;
  } dp_stat_t;

endpackage

@@ src/lcg48_if.sv @@
// Valid/ready channel interface for the LCG block.
// Depends on nothing; payload width set by parameter.
interface lcg48_if #(
  parameter int unsigned Width = 8
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/lcg48_dp.sv @@
// Datapath of the LCG block: state, 48x48 step multiply in 3 partial products,
// restoring divider for bounded int, result assembly. Uses lcg48_pkg.
module lcg48_dp
  import lcg48_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [104:0]  in_data_i,
  input  dp_cmd_t       cmd_i,
  input  logic [1:0]    part_i,
  output dp_stat_t      stat_o,
  output logic [64:0]   result_o
);

  logic [47:0] state_q;
  logic [2:0]  op_q;
  logic [5:0]  k_q;
  logic [31:0] bound_q;
  logic [63:0] seed_q;
  logic [47:0] acc_q;
  logic [31:0] hi_q;
  logic [30:0] rem_q, quo_q;
  logic [4:0]  dcnt_q;
  logic [63:0] value_q;
  logic        err_q;
  logic [47:0] pp;
  logic [31:0] r31, v31, chk;
  logic [5:0]  kk;
  logic [31:0] draw;
  logic [31:0] trial;

  // Partial product: 16-bit slice of multiplier times state, shifted
  always_comb begin
    unique case (part_i)
      2'd0:    pp = state_q * {32'd0, LcgMult[15:0]};
      2'd1:    pp = (state_q * {32'd0, LcgMult[31:16]}) << 16;
      default: pp = (state_q * {32'd0, LcgMult[47:32]}) << 32;
    endcase
  end

  // Top-k draw from current state: k capped at 32 for bits, 31 for bounded, 26 then 27 for double, else 32 bits
  always_comb begin
    kk = (k_q > 6'd32) ? 6'd32 : k_q;
    unique case (op_q)
      OP_BITS:   draw = (kk == 6'd0) ? 32'd0 : 32'(state_q >> (6'd48 - kk));
      OP_BOUNDED: draw = {1'b0, state_q[47:17]};
      OP_DOUBLE: draw = (hi_q == 32'hFFFFFFFF) ? 32'(state_q[47:22]) : 32'(state_q[47:21]);
      default:   draw = state_q[47:16];
    endcase
  end

  assign r31   = {1'b0, state_q[47:17]};
  assign v31   = {1'b0, rem_q};
  assign chk   = r31 - v31 + (bound_q - 32'd1);
  assign trial = {rem_q, quo_q[30]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LcgMult;
    end else if (cmd_i.reseed) begin
      state_q <= seed_q[47:0] ^ LcgMult;
    end else if (cmd_i.step_done) begin
      state_q <= acc_q + pp + LcgInc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= in_data_i[104:102];
      k_q     <= in_data_i[101:96];
      bound_q <= in_data_i[95:64];
      seed_q  <= in_data_i[63:0];
      hi_q    <= 32'hFFFFFFFF;
      err_q   <= 1'b0;
      value_q <= 64'd0;
    end
    if (cmd_i.step_start) begin
      acc_q <= pp;
    end else if (!cmd_i.step_done) begin
      acc_q <= acc_q + pp;
    end
    if (cmd_i.set_hi) begin
      hi_q <= draw;
    end
    // Restoring division of 31-bit draw by bound, one bit per cycle
    if (cmd_i.div_start) begin
      rem_q  <= 31'd0;
      quo_q  <= state_q[47:17];
      dcnt_q <= 5'd30;
    end else if (cmd_i.div_step) begin
      if (trial >= bound_q) begin
        rem_q <= 31'(trial - bound_q);
      end else begin
        rem_q <= trial[30:0];
      end
      quo_q  <= {quo_q[29:0], 1'b0};
      dcnt_q <= dcnt_q - 5'd1;
    end
    if (cmd_i.set_error) begin
      err_q   <= 1'b1;
      value_q <= '1;
    end else if (cmd_i.set_result) begin
      unique case (op_q)
        OP_BITS:    value_q <= {{32{draw[31]}}, draw};
        OP_BOUNDED: begin
          if (stat_o.bound_pow2) begin
            value_q <= 64'((64'(bound_q) * 64'(r31)) >> 31);
          end else begin
            value_q <= {33'd0, rem_q};
          end
        end
        OP_LONG:    value_q <= {hi_q, 32'd0} + {{32{draw[31]}}, draw};
        OP_DOUBLE:  value_q <= (64'(hi_q[25:0]) << 27) + 64'(draw[26:0]);
        default:    value_q <= 64'd0;
      endcase
    end
  end

  assign stat_o.op         = op_q;
  assign stat_o.bound_bad  = (bound_q == 32'd0) || bound_q[31];
  assign stat_o.bound_pow2 = ((bound_q & (bound_q - 32'd1)) == 32'd0);
  assign stat_o.div_last   = (dcnt_q == 5'd0);
  assign stat_o.reject     = chk[31];
  assign result_o          = {err_q, value_q};

endmodule

@@ src/lcg48_ctrl.sv @@
// Controller of the LCG block: sequences steps, division and result.
// Uses lcg48_pkg command/status types.
module lcg48_ctrl
  import lcg48_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic [1:0] part_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_MUL, S_DIV, S_CHECK, S_DONE
  } state_e;

  state_e     st_q;
  logic [1:0] part_q;
  logic       second_q;
  logic       busy_out_q;

  assign in_ready_o  = (st_q == S_IDLE) && !busy_out_q;
  assign out_valid_o = busy_out_q;
  assign part_o      = part_q;

  // Commands decoded from state
  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = in_valid_i && in_ready_o;
    cmd_o.step_start = (st_q == S_MUL) && (part_q == 2'd0);
    cmd_o.step_done  = (st_q == S_MUL) && (part_q == 2'd2);
    cmd_o.div_step   = (st_q == S_DIV);
    cmd_o.reseed     = (st_q == S_DECODE) && (stat_i.op == OP_RESEED);
    cmd_o.set_error  = (st_q == S_DECODE) && (stat_i.op == OP_BOUNDED) && stat_i.bound_bad;
    cmd_o.set_hi     = (st_q == S_DONE) && !second_q &&
                       ((stat_i.op == OP_LONG) || (stat_i.op == OP_DOUBLE));
    cmd_o.div_start  = (st_q == S_DONE) && (stat_i.op == OP_BOUNDED) && !stat_i.bound_pow2;
    cmd_o.set_result = ((st_q == S_DONE) && !cmd_o.set_hi && !cmd_o.div_start) ||
                       ((st_q == S_CHECK) && !stat_i.reject);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      part_q     <= 2'd0;
      second_q   <= 1'b0;
      busy_out_q <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        busy_out_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (cmd_o.load) begin
            st_q     <= S_DECODE;
            second_q <= 1'b0;
          end
        end
        S_DECODE: begin
          part_q <= 2'd0;
          if ((stat_i.op == OP_RESEED) || (stat_i.op > OP_DOUBLE) ||
              ((stat_i.op == OP_BOUNDED) && stat_i.bound_bad)) begin
            busy_out_q <= 1'b1;
            st_q       <= S_IDLE;
          end else begin
            st_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (part_q == 2'd2) begin
            part_q <= 2'd0;
            st_q   <= S_DONE;
          end else begin
            part_q <= part_q + 2'd1;
          end
        end
        S_DONE: begin
          if (cmd_o.set_hi) begin
            second_q <= 1'b1;
            st_q     <= S_MUL;
          end else if (cmd_o.div_start) begin
            st_q <= S_DIV;
          end else begin
            busy_out_q <= 1'b1;
            st_q       <= S_IDLE;
          end
        end
        S_DIV: begin
          if (stat_i.div_last) begin
            st_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (stat_i.reject) begin
            st_q <= S_MUL;
          end else begin
            busy_out_q <= 1'b1;
            st_q       <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/lcg48_random_draws.sv @@
// Top level of the 48-bit LCG random draw block.
// Channels: in_if carries {operation, bits_wanted, bound, new_seed}; out_if
// carries {error, value}. One result transaction per input transaction.
// Reseed, bad bound and unused codes answer from decode with no step; a draw
// takes a step multiply in 16-bit slices; long and double take a step for
// each of their high and low draws; bounded int with a non-power-of-two
// bound takes a step, the restoring divider and a rejection check, plus
// these again for each rejected draw.
// One transaction is worked at a time; the next is taken once the result
// has been delivered. The result register holds while the receiver stalls.
// Reset sets the generator state to the scrambled zero seed 0x5DEECE66D.
// Uses lcg48_pkg, lcg48_if, lcg48_ctrl, lcg48_dp.
module lcg48_random_draws
  import lcg48_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  lcg48_if.sink   in_if,
  lcg48_if.source out_if
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [1:0] part;
  logic [64:0] result;

  lcg48_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .part_o     (part)
  );

  lcg48_dp u_dp (
    .clk_i, .rst_ni,
    .in_data_i(in_if.data[104:0]),
    .cmd_i    (cmd),
    .part_i   (part),
    .stat_o   (stat),
    .result_o (result)
  );

  assign out_if.data = result;

`ifndef SYNTHESIS
  // no new transaction while a result is pending
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready) else $error("accept while result pending");
  // error flag only with all-ones value
  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.data[64]) |-> (out_if.data[63:0] == '1))
    else $error("error without -1 value");
`endif

endmodule

@@ bench/lcg48_random_draws_tb.sv @@
// Testbench for the 48-bit LCG random draw block: directed and random requests
// checked against an in-bench generator model held in a scoreboard class.
// Depends on lcg48_pkg, lcg48_if and the lcg48_random_draws RTL.
`timescale 1ns / 1ps

module lcg48_random_draws_tb;
  import lcg48_pkg::*;

  localparam int unsigned InW  = 3 + 6 + 32 + 64;
  localparam int unsigned OutW = 1 + 64;
  localparam int unsigned WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lcg48_if #(.Width(InW))  req_if ();
  lcg48_if #(.Width(OutW)) rsp_if ();

  lcg48_random_draws uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (req_if.sink),
    .out_if (rsp_if.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  typedef struct packed {
    logic        error;
    logic [63:0] value;
  } draw_rsp_t;

  // Generator model and queue of expected draws
  class draw_scoreboard;
    logic [47:0] gen_state;
    draw_rsp_t   pending[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      gen_state = LcgMult;
      errors = 0;
      checked = 0;
    endfunction

    function logic [31:0] next_top(int unsigned k);
      logic [47:0] s;
      s = gen_state * LcgMult + LcgInc;
      gen_state = s;
      if (k == 0) return 32'd0;
      if (k > 32) k = 32;
      return 32'(s >> (48 - k));
    endfunction

    // Work out the result of one accepted request
    function void note_request(logic [2:0] op, logic [5:0] nbits,
                               logic [31:0] bnd, logic [63:0] seed);
      draw_rsp_t   r;
      logic [31:0] d, v, hi;
      logic [63:0] prod;
      r = '0;
      case (op)
        OP_RESEED: gen_state = seed[47:0] ^ LcgMult;
        OP_BITS: begin
          d = next_top(nbits);
          r.value = {{32{d[31]}}, d};
        end
        OP_BOUNDED: begin
          if (bnd == 0 || bnd[31]) begin
            r.error = 1'b1;
            r.value = '1;
          end else if ((bnd & (bnd - 1)) == 0) begin
            prod = 64'(bnd) * 64'(next_top(31));
            r.value = prod >> 31;
          end else begin
            do begin
              d = next_top(31);
              v = d % bnd;
            end while (((d - v + (bnd - 1)) & 32'h8000_0000) != 0);
            r.value = 64'(v);
          end
        end
        OP_LONG: begin
          hi = next_top(32);
          d = next_top(32);
          r.value = {hi, 32'd0} + {{32{d[31]}}, d};
        end
        OP_DOUBLE: begin
          hi = next_top(26);
          d = next_top(27);
          r.value = (64'(hi) << 27) + 64'(d);
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(draw_rsp_t got);
      draw_rsp_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result transaction value=%h error=%b", got.value, got.error);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.value !== exp_r.value) begin
        $error("value: expected %h, got %h", exp_r.value, got.value);
        errors++;
      end
      if (got.error !== exp_r.error) begin
        $error("error: expected %b, got %b", exp_r.error, got.error);
        errors++;
      end
    endfunction
  endclass

  draw_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned reqs_sent = 0;
  bit stim_done = 1'b0;

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
  end

  // Request side: model on acceptance; result side: check on handshake; idle count for the watchdog
  always @(posedge clk_i) begin
    if (req_if.valid && req_if.ready) begin
      sb.note_request(req_if.data[104:102], req_if.data[101:96],
                      req_if.data[95:64], req_if.data[63:0]);
      reqs_sent++;
    end
    if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  // Receiver stalls: random wait before ready for each result
  initial begin
    int unsigned w;
    @(posedge rst_ni);
    forever begin
      w = $urandom_range(0, 3);
      rsp_if.ready <= (w == 0);
      while (w > 0) begin
        @(posedge clk_i);
        w--;
        if (w == 0) rsp_if.ready <= 1'b1;
      end
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  // Valid stays high after a transaction unless the next one waits first
  task automatic send_req(logic [2:0] op, logic [5:0] nbits,
                          logic [31:0] bnd, logic [63:0] seed);
    int unsigned w;
    w = $urandom_range(0, 3);
    if (w > 0) begin
      req_if.valid <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= {op, nbits, bnd, seed};
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Drop valid and let the last accepted transaction reach the model
  task automatic idle_req();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly useful bounds: small, power of two, near 2^31, odd extremes
  function automatic logic [31:0] rand_bound();
    case ($urandom_range(0, 6))
      0: return 32'd1 << $urandom_range(0, 30);
      1: return $urandom_range(1, 100);
      2: return 32'h4000_0000 + $urandom_range(1, 32'h3FFF_FFFF);
      3: return {1'b1, 31'($urandom())};
      4: return 32'd0;
      default: return {1'b0, 31'($urandom())};
    endcase
  endfunction

  initial begin
    logic [2:0] op;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: every operation, field extremes, special cases
    send_req(OP_BITS, 6'd1, '0, '0);
    send_req(OP_BITS, 6'd32, '0, '0);
    send_req(OP_BITS, 6'd0, '0, '0);
    send_req(OP_BITS, 6'd63, '1, '1);
    send_req(OP_BITS, 6'd33, '0, '0);
    send_req(OP_BOUNDED, '0, 32'd0, '0);
    send_req(OP_BOUNDED, '0, 32'h8000_0000, '0);
    send_req(OP_BOUNDED, '0, 32'hFFFF_FFFF, '0);
    send_req(OP_BOUNDED, '0, 32'd1, '0);
    send_req(OP_BOUNDED, '0, 32'h4000_0000, '0);
    send_req(OP_BOUNDED, '0, 32'h7FFF_FFFF, '0);
    send_req(OP_BOUNDED, '0, 32'h4000_0001, '0);
    send_req(OP_BOUNDED, '0, 32'd3, '0);
    send_req(OP_LONG, '0, '0, '0);
    send_req(OP_DOUBLE, '0, '0, '0);
    send_req(OP_RESEED, '0, '0, 64'h8000_0000_0000_0000);
    send_req(OP_LONG, '0, '0, '0);
    send_req(OP_RESEED, '0, '0, '1);
    send_req(OP_DOUBLE, '0, '0, '0);
    send_req(OP_RESEED, '0, '0, 64'd0);
    send_req(3'd5, 6'd1, 32'd5, '1);
    send_req(3'd6, '0, '0, '0);
    send_req(3'd7, '1, '1, '1);
    send_req(OP_BITS, 6'd17, '0, '0);
    idle_req();

    // Hold off until the block has drained
    wait (sb.pending.size() == 0);
    @(posedge clk_i);

    // Random part: mostly valid operations, some unused codes
    repeat (1100) begin
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
      send_req(op, ($urandom_range(0, 9) == 0) ? 6'($urandom()) : 6'($urandom_range(1, 32)),
               rand_bound(), rand64());
    end
    idle_req();
    stim_done = 1'b1;
  end

  // End of run and watchdog
  initial begin
    wait (stim_done && sb.pending.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("Ran %0d requests over all five operations, reseeds and bad bounds;",
             reqs_sent);
    $display("%0d results compared against the generator model.", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit);
    $error("watchdog: no transaction for %0d cycles", WatchdogLimit);
    $display("FAIL");
    $finish;
  end

endmodule

@@ lcg48_random_draws.f @@
src/lcg48_pkg.sv
src/lcg48_if.sv
src/lcg48_dp.sv
src/lcg48_ctrl.sv
src/lcg48_random_draws.sv
bench/lcg48_random_draws_tb.sv
